>>> sv/fdc_pkg.sv
package fdc_pkg;

  localparam int MAX_PAYLOAD_DEF  = 48;
  localparam int BUFFER_BYTES_DEF = 64;
  localparam int HDR_BYTES        = 6;
  localparam int RESULT_CAP       = 48;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  typedef enum logic [0:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_SHORT    = 3'd1,
    KIND_LONG     = 3'd2,
    KIND_CRC      = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_H0,
    S_H1,
    S_H2,
    S_HEV,
    S_CRC,
    S_CEV,
    S_DRD,
    S_DEM,
    S_FIN
  } state_e;

  // one byte through the reflected CRC-16, one bit per step
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> sv/frame_deframer_crc16_core.sv
// Flow: an accepted byte is written to the frame memory; each header check reads four header
// bytes, and a complete frame adds a CRC pass over all its bytes and a read per payload byte.
// Throughput: one byte at a time; in_ready_o stays low until the byte has been handled, and
// all passes share the single read port of the frame memory.
// Reset: asynchronous, active low; clears fill count, head pointer and handshakes and
// loads the sync registers with 0xAA and 0x55. Memory contents are not cleared.
module frame_deframer_crc16_core #(
  parameter int MAX_PAYLOAD  = fdc_pkg::MAX_PAYLOAD_DEF,
  parameter int BUFFER_BYTES = fdc_pkg::BUFFER_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] cmd_o,
  output logic [7:0] seq_o,
  output logic [5:0] payload_len_o,
  output logic       has_data_o,
  output logic [7:0] data_byte_o,
  output logic       last_o
);

  localparam int AW  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int FW  = $clog2(BUFFER_BYTES + 1);
  localparam int PW  = $clog2(MAX_PAYLOAD + 1);
  localparam int TW  = $clog2(MAX_PAYLOAD + fdc_pkg::HDR_BYTES + 3);
  localparam int CW  = (FW > TW) ? FW : TW;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [FW-1:0] b);
    logic [FW:0] s;
    s = (FW+1)'(a) + (FW+1)'(b);
    if (s >= (FW+1)'(BUFFER_BYTES)) begin
      s = s - (FW+1)'(BUFFER_BYTES);
    end
    return s[AW-1:0];
  endfunction

  fdc_pkg::state_e state_q, state_d;

  logic [7:0]    sync_first_q, sync_second_q;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]    b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  logic [FW-1:0] total_q, total_d;
  logic [PW-1:0] plen_q, plen_d;
  logic [PW-1:0] idx_q, idx_d;
  logic [FW-1:0] iss_q, iss_d;
  logic [FW-1:0] ridx_q;
  logic          rvalid_q;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   rx_crc_q, rx_crc_d;
  logic [7:0]    cmd_q, cmd_d, seq_q, seq_d;

  // frame memory, circular around head_q
  logic [7:0]    frame_mem_q [BUFFER_BYTES];
  logic [7:0]    rdata_q;
  logic          rd_en, wr_en;
  logic [FW-1:0] rd_off;
  logic [AW-1:0] rd_addr, wr_addr;

  logic          drop_en;
  logic [FW-1:0] drop_n;

  // one-result lookahead so the final result of a run can be tagged last
  logic          pend_v_q;
  fdc_pkg::kind_e pend_kind_q;
  logic [7:0]    pend_cmd_q, pend_seq_q, pend_data_q;
  logic [5:0]    pend_len_q;
  logic          pend_has_q;

  logic          out_v_q;
  logic [2:0]    out_kind_q;
  logic [7:0]    out_cmd_q, out_seq_q, out_data_q;
  logic [5:0]    out_len_q;
  logic          out_has_q, out_last_q;

  // results given so far in this run; beyond the cap they are dropped
  logic [5:0]    nres_q;
  logic          cap_hit, emit_go;

  logic          emit, flush, out_free, can_emit, out_load;
  fdc_pkg::kind_e emit_kind;
  logic [7:0]    emit_cmd, emit_seq, emit_data;
  logic [5:0]    emit_len;
  logic          emit_has;

  logic [15:0]   body;
  logic          sync_ok;
  logic [CW-1:0] total_c;

  assign out_free = !out_v_q || out_ready_i;
  assign cap_hit  = (nres_q == 6'(fdc_pkg::RESULT_CAP));
  assign can_emit = cap_hit || !pend_v_q || out_free;
  assign emit_go  = emit && can_emit && !cap_hit;
  assign out_load = (emit_go && pend_v_q) || flush;

  assign body    = {rdata_q, b2_q};
  assign sync_ok = (b0_q == sync_first_q) && (b1_q == sync_second_q);
  assign total_c = CW'(body) + CW'(fdc_pkg::HDR_BYTES);

  assign in_ready_o = (state_q == fdc_pkg::S_IDLE);
  assign wr_addr    = wrap_add(head_q, fill_q);
  assign rd_addr    = wrap_add(head_q, rd_off);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    b2_d      = b2_q;
    total_d   = total_q;
    plen_d    = plen_q;
    idx_d     = idx_q;
    iss_d     = iss_q;
    crc_d     = crc_q;
    rx_crc_d  = rx_crc_q;
    cmd_d     = cmd_q;
    seq_d     = seq_q;
    rd_en     = 1'b0;
    rd_off    = '0;
    wr_en     = 1'b0;
    drop_en   = 1'b0;
    drop_n    = '0;
    emit      = 1'b0;
    emit_kind = fdc_pkg::KIND_DATA;
    emit_cmd  = '0;
    emit_seq  = '0;
    emit_len  = '0;
    emit_has  = 1'b0;
    emit_data = '0;
    flush     = 1'b0;

    unique case (state_q)
      fdc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (fill_q == FW'(BUFFER_BYTES)) begin
            // store full: clear it, drop the byte, report overflow
            fill_d    = '0;
            emit      = 1'b1;
            emit_kind = fdc_pkg::KIND_OVERFLOW;
            state_d   = fdc_pkg::S_FIN;
          end else begin
            wr_en   = 1'b1;
            fill_d  = fill_q + FW'(1);
            state_d = fdc_pkg::S_CHECK;
          end
        end
      end
      fdc_pkg::S_CHECK: begin
        if (fill_q < FW'(fdc_pkg::HDR_BYTES)) begin
          state_d = fdc_pkg::S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_off  = FW'(0);
          state_d = fdc_pkg::S_H0;
        end
      end
      fdc_pkg::S_H0: begin
        b0_d    = rdata_q;
        rd_en   = 1'b1;
        rd_off  = FW'(1);
        state_d = fdc_pkg::S_H1;
      end
      fdc_pkg::S_H1: begin
        b1_d    = rdata_q;
        rd_en   = 1'b1;
        rd_off  = FW'(2);
        state_d = fdc_pkg::S_H2;
      end
      fdc_pkg::S_H2: begin
        b2_d    = rdata_q;
        rd_en   = 1'b1;
        rd_off  = FW'(3);
        state_d = fdc_pkg::S_HEV;
      end
      fdc_pkg::S_HEV: begin
        priority if (!sync_ok) begin
          drop_en = 1'b1;
          drop_n  = FW'(1);
          state_d = fdc_pkg::S_CHECK;
        end else if (body < 16'd2) begin
          emit      = 1'b1;
          emit_kind = fdc_pkg::KIND_SHORT;
          if (can_emit) begin
            drop_en = 1'b1;
            drop_n  = FW'(2);
            state_d = fdc_pkg::S_CHECK;
          end
        end else if (body > 16'(MAX_PAYLOAD + 2)) begin
          emit      = 1'b1;
          emit_kind = fdc_pkg::KIND_LONG;
          if (can_emit) begin
            drop_en = 1'b1;
            drop_n  = FW'(2);
            state_d = fdc_pkg::S_CHECK;
          end
        end else if (CW'(fill_q) < total_c) begin
          // frame not complete yet: wait for more bytes
          state_d = fdc_pkg::S_FIN;
        end else begin
          total_d = FW'(total_c);
          plen_d  = PW'(body - 16'd2);
          crc_d   = fdc_pkg::CRC_INIT;
          iss_d   = '0;
          state_d = fdc_pkg::S_CRC;
        end
      end
      fdc_pkg::S_CRC: begin
        if (iss_q != total_q) begin
          rd_en  = 1'b1;
          rd_off = iss_q;
          iss_d  = iss_q + FW'(1);
        end
        if (rvalid_q) begin
          priority if (ridx_q == total_q - FW'(2)) begin
            rx_crc_d[7:0] = rdata_q;
          end else if (ridx_q == total_q - FW'(1)) begin
            rx_crc_d[15:8] = rdata_q;
            state_d        = fdc_pkg::S_CEV;
          end else begin
            crc_d = fdc_pkg::crc16_byte(crc_q, rdata_q);
            if (ridx_q == FW'(4)) begin
              cmd_d = rdata_q;
            end
            if (ridx_q == FW'(5)) begin
              seq_d = rdata_q;
            end
          end
        end
      end
      fdc_pkg::S_CEV: begin
        priority if (rx_crc_q != crc_q) begin
          emit      = 1'b1;
          emit_kind = fdc_pkg::KIND_CRC;
          if (can_emit) begin
            drop_en = 1'b1;
            drop_n  = total_q;
            state_d = fdc_pkg::S_CHECK;
          end
        end else if (plen_q == '0) begin
          emit      = 1'b1;
          emit_kind = fdc_pkg::KIND_DATA;
          emit_cmd  = cmd_q;
          emit_seq  = seq_q;
          if (can_emit) begin
            drop_en = 1'b1;
            drop_n  = total_q;
            state_d = fdc_pkg::S_CHECK;
          end
        end else begin
          idx_d   = '0;
          state_d = fdc_pkg::S_DRD;
        end
      end
      fdc_pkg::S_DRD: begin
        rd_en   = 1'b1;
        rd_off  = FW'(fdc_pkg::HDR_BYTES) + FW'(idx_q);
        state_d = fdc_pkg::S_DEM;
      end
      fdc_pkg::S_DEM: begin
        emit      = 1'b1;
        emit_kind = fdc_pkg::KIND_DATA;
        emit_cmd  = cmd_q;
        emit_seq  = seq_q;
        emit_len  = 6'(plen_q);
        emit_has  = 1'b1;
        emit_data = rdata_q;
        if (can_emit) begin
          if (idx_q == plen_q - PW'(1)) begin
            drop_en = 1'b1;
            drop_n  = total_q;
            state_d = fdc_pkg::S_CHECK;
          end else begin
            idx_d   = idx_q + PW'(1);
            state_d = fdc_pkg::S_DRD;
          end
        end
      end
      fdc_pkg::S_FIN: begin
        if (pend_v_q) begin
          if (out_free) begin
            flush   = 1'b1;
            state_d = fdc_pkg::S_IDLE;
          end
        end else begin
          state_d = fdc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fdc_pkg::S_IDLE;
      end
    endcase

    if (drop_en) begin
      head_d = wrap_add(head_q, drop_n);
      fill_d = fill_q - drop_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fdc_pkg::S_IDLE;
      head_q        <= '0;
      fill_q        <= '0;
      rvalid_q      <= 1'b0;
      pend_v_q      <= 1'b0;
      out_v_q       <= 1'b0;
      nres_q        <= '0;
      sync_first_q  <= fdc_pkg::SYNC_FIRST_RST;
      sync_second_q <= fdc_pkg::SYNC_SECOND_RST;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      rvalid_q <= rd_en;
      if (flush) begin
        pend_v_q <= 1'b0;
      end else if (emit_go) begin
        pend_v_q <= 1'b1;
      end
      if (state_q == fdc_pkg::S_FIN) begin
        nres_q <= '0;
      end else if (emit_go) begin
        nres_q <= nres_q + 6'd1;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (fdc_pkg::cfg_idx_e'(cfg_idx_i))
          fdc_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
          fdc_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q     <= b0_d;
    b1_q     <= b1_d;
    b2_q     <= b2_d;
    total_q  <= total_d;
    plen_q   <= plen_d;
    idx_q    <= idx_d;
    iss_q    <= iss_d;
    crc_q    <= crc_d;
    rx_crc_q <= rx_crc_d;
    cmd_q    <= cmd_d;
    seq_q    <= seq_d;
    if (rd_en) begin
      ridx_q <= rd_off;
    end
    if (emit_go) begin
      pend_kind_q <= emit_kind;
      pend_cmd_q  <= emit_cmd;
      pend_seq_q  <= emit_seq;
      pend_len_q  <= emit_len;
      pend_has_q  <= emit_has;
      pend_data_q <= emit_data;
    end
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_cmd_q  <= pend_cmd_q;
      out_seq_q  <= pend_seq_q;
      out_len_q  <= pend_len_q;
      out_has_q  <= pend_has_q;
      out_data_q <= pend_data_q;
      out_last_q <= flush;
    end
  end

  // writes happen only while idle, so reads never race a write to the same entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem_q[wr_addr] <= rx_byte_i;
    end
    if (rd_en) begin
      rdata_q <= frame_mem_q[rd_addr];
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_kind_q;
  assign cmd_o         = out_cmd_q;
  assign seq_o         = out_seq_q;
  assign payload_len_o = out_len_q;
  assign has_data_o    = out_has_q;
  assign data_byte_o   = out_data_q;
  assign last_o        = out_last_q;

endmodule

>>> sv/fdc_checker.sv
module fdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] kind_o,
  input logic [7:0] cmd_o,
  input logic [7:0] seq_o,
  input logic [5:0] payload_len_o,
  input logic       has_data_o,
  input logic [7:0] data_byte_o,
  input logic       last_o
);

  // a stalled result request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(data_byte_o)
      && $stable(last_o) && $stable(has_data_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == fdc_pkg::KIND_OVERFLOW |-> last_o)
    else $error("overflow result not last of its run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != fdc_pkg::KIND_DATA |->
      cmd_o == 8'd0 && seq_o == 8'd0 && payload_len_o == 6'd0 && !has_data_o
      && data_byte_o == 8'd0)
    else $error("error result carries frame fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |-> kind_o == fdc_pkg::KIND_DATA)
    else $error("payload byte on an error result");

endmodule

bind frame_deframer_crc16_core fdc_checker u_fdc_checker (.*);
